>>> design/fsge_pkg.sv
package fsge_pkg;

  localparam int GRID_WIDTH  = 256;
  localparam int GRID_HEIGHT = 256;
  localparam int X_W         = $clog2(GRID_WIDTH);
  localparam int Y_W         = $clog2(GRID_HEIGHT);
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;

  localparam logic [1:0] OP_PAINT = 2'd0;
  localparam logic [1:0] OP_SWEEP = 2'd1;
  localparam logic [1:0] OP_READ  = 2'd2;

  localparam logic [CFG_IDX_W-1:0] REG_LFSR_SEED    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BRUSH_HALF_W = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BRUSH_HALF_H = 2'd2;

  localparam logic [15:0] LFSR_RESET    = 16'd1;
  localparam logic [5:0]  HALF_W_RESET  = 6'd10;
  localparam logic [6:0]  HALF_H_RESET  = 7'd20;
  localparam logic [15:0] MOVES_MAX     = 16'hFFFF;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_RD_ISSUE,
    ST_PT_ISSUE,
    ST_PT_WRITE,
    ST_SW_COLRD,
    ST_SW_COLCAP,
    ST_SW_RD,
    ST_SW_EVAL,
    ST_SW_COLWR,
    ST_RESP
  } state_t;

  typedef enum logic [3:0] {
    DP_NOP,
    DP_CLEAR_WR,
    DP_LOAD,
    DP_RD_ROW,
    DP_RD_NEXT,
    DP_CAP_ROW,
    DP_PT_WR,
    DP_SW_EVAL,
    DP_SW_COLWR,
    DP_RESP
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
  } cmd_t;

  typedef struct packed {
    logic clear_last;
    logic pt_empty;
    logic pt_row_last;
    logic sw_row_last;
    logic sw_col_last;
    logic out_busy;
  } status_t;

endpackage

>>> design/fsge_if.sv
interface fsge_in_if;
  logic       valid;
  logic       ready;
  logic [1:0] operation;
  logic [7:0] pos_x;
  logic [7:0] pos_y;

  modport source (output valid, output operation, output pos_x, output pos_y, input ready);
  modport sink (input valid, input operation, input pos_x, input pos_y, output ready);
endinterface

interface fsge_out_if;
  logic        valid;
  logic        ready;
  logic        cell_is_sand;
  logic [15:0] grains_moved;

  modport source (output valid, output cell_is_sand, output grains_moved, input ready);
  modport sink (input valid, input cell_is_sand, input grains_moved, output ready);
endinterface

interface fsge_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  reg_index;
  logic [15:0] wr_data;

  modport source (output valid, output reg_index, output wr_data, input ready);
  modport sink (input valid, input reg_index, input wr_data, output ready);
endinterface

>>> design/fsge_ctrl.sv
module fsge_ctrl
  import fsge_pkg::*;
(
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  input  logic [1:0] in_operation,
  input  status_t    status,
  output logic       in_ready,
  output cmd_t       cmd
);

  state_t state;
  state_t state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_CLEAR;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (status.clear_last) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          case (in_operation)
            OP_PAINT: state_next = ST_PT_ISSUE;
            OP_SWEEP: state_next = ST_SW_COLRD;
            OP_READ:  state_next = ST_RD_ISSUE;
            default:  state_next = ST_RESP;
          endcase
        end
      end
      ST_RD_ISSUE: state_next = ST_RESP;
      ST_PT_ISSUE: begin
        if (status.pt_empty) state_next = ST_RESP;
        else state_next = ST_PT_WRITE;
      end
      ST_PT_WRITE: begin
        if (status.pt_row_last) state_next = ST_RESP;
        else state_next = ST_PT_ISSUE;
      end
      ST_SW_COLRD:  state_next = ST_SW_COLCAP;
      ST_SW_COLCAP: state_next = ST_SW_RD;
      ST_SW_RD:     state_next = ST_SW_EVAL;
      ST_SW_EVAL: begin
        if (status.sw_row_last) state_next = ST_SW_COLWR;
        else state_next = ST_SW_RD;
      end
      ST_SW_COLWR: begin
        if (status.sw_col_last) state_next = ST_RESP;
        else state_next = ST_SW_COLRD;
      end
      ST_RESP: begin
        if (!status.out_busy) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  always_comb begin
    in_ready = 1'b0;
    cmd.op   = DP_NOP;
    case (state)
      ST_CLEAR: cmd.op = DP_CLEAR_WR;
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) cmd.op = DP_LOAD;
      end
      ST_RD_ISSUE: cmd.op = DP_RD_ROW;
      ST_PT_ISSUE: begin
        if (!status.pt_empty) cmd.op = DP_RD_ROW;
      end
      ST_PT_WRITE:  cmd.op = DP_PT_WR;
      ST_SW_COLRD:  cmd.op = DP_RD_ROW;
      ST_SW_COLCAP: cmd.op = DP_CAP_ROW;
      ST_SW_RD:     cmd.op = DP_RD_NEXT;
      ST_SW_EVAL:   cmd.op = DP_SW_EVAL;
      ST_SW_COLWR:  cmd.op = DP_SW_COLWR;
      ST_RESP: begin
        if (!status.out_busy) cmd.op = DP_RESP;
      end
      default: cmd.op = DP_NOP;
    endcase
  end

endmodule

>>> design/fsge_dp.sv
module fsge_dp
  import fsge_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst,
  input  cmd_t                  cmd,
  output status_t               status,
  input  logic [1:0]            in_operation,
  input  logic [7:0]            in_pos_x,
  input  logic [7:0]            in_pos_y,
  input  logic                  cfg_valid,
  input  logic [CFG_IDX_W-1:0]  cfg_reg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wr_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic                  out_cell_is_sand,
  output logic [15:0]           out_grains_moved
);

  function automatic logic signed [11:0] span_lo(logic [7:0] c, logic [6:0] h);
    return $signed({4'b0, c}) - $signed({5'b0, h}) + 12'sd1;
  endfunction

  function automatic logic signed [11:0] span_hi(logic [7:0] c, logic [6:0] h);
    return $signed({4'b0, c}) + $signed({5'b0, h}) - 12'sd1;
  endfunction

  logic [GRID_WIDTH-1:0] mem [GRID_HEIGHT];
  logic [GRID_WIDTH-1:0] rd_data;
  logic                  mem_we;
  logic                  mem_re;
  logic [Y_W-1:0]        mem_waddr;
  logic [Y_W-1:0]        mem_raddr;
  logic [GRID_WIDTH-1:0] mem_wdata;

  logic [Y_W-1:0]        row_idx;
  logic [X_W-1:0]        col_idx;
  logic [GRID_WIDTH-1:0] row_buf;
  logic [15:0]           lfsr;
  logic [5:0]            half_w;
  logic [6:0]            half_h;
  logic [1:0]            op_r;
  logic [7:0]            px_r;
  logic [7:0]            py_r;
  logic [15:0]           moves;

  logic signed [11:0]    x_lo;
  logic signed [11:0]    x_hi;
  logic signed [11:0]    y_lo_in;
  logic signed [11:0]    y_lo_in_c;
  logic signed [11:0]    y_lo;
  logic signed [11:0]    y_hi;
  logic signed [11:0]    y_hi_c;
  logic [GRID_WIDTH-1:0] paint_mask;

  logic                  cell_here;
  logic                  below;
  logic                  below_l;
  logic                  below_r;
  logic                  interior;
  logic                  draw;
  logic                  move;
  logic [X_W-1:0]        tx;
  logic [GRID_WIDTH-1:0] row_cur_wr;
  logic [GRID_WIDTH-1:0] row_buf_next;
  logic                  lfsr_fb;
  logic                  read_in_range;

  always_comb begin
    x_lo      = span_lo(px_r, {1'b0, half_w});
    x_hi      = span_hi(px_r, {1'b0, half_w});
    y_lo      = span_lo(py_r, half_h);
    y_hi      = span_hi(py_r, half_h);
    y_lo_in   = span_lo(in_pos_y, half_h);
    y_lo_in_c = (y_lo_in < 12'sd0) ? 12'sd0 : y_lo_in;
    y_hi_c    = (int'(y_hi) > GRID_HEIGHT - 1) ? 12'(GRID_HEIGHT - 1) : y_hi;
    for (int i = 0; i < GRID_WIDTH; i++) begin
      paint_mask[i] = (i >= int'(x_lo)) && (i <= int'(x_hi));
    end
  end

  always_comb begin
    cell_here = row_buf[col_idx];
    below     = rd_data[col_idx];
    below_l   = rd_data[col_idx - 1'b1];
    below_r   = rd_data[col_idx + 1'b1];
    interior  = (col_idx != '0) && (col_idx != X_W'(GRID_WIDTH - 1)) && (row_idx != '0);
    draw      = cell_here && below && interior;
    move      = 1'b0;
    tx        = col_idx;
    if (cell_here) begin
      if (!below) begin
        move = 1'b1;
      end else if (interior) begin
        if (lfsr[0] && !below_l) begin
          move = 1'b1;
          tx   = col_idx - 1'b1;
        end else if (!below_r) begin
          move = 1'b1;
          tx   = col_idx + 1'b1;
        end
      end
    end
    row_cur_wr   = row_buf;
    row_buf_next = rd_data;
    if (move) begin
      row_cur_wr[col_idx] = 1'b0;
      row_buf_next[tx]    = 1'b1;
    end
    lfsr_fb = lfsr[0] ^ lfsr[2] ^ lfsr[3] ^ lfsr[5];
  end

  always_comb begin
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = row_idx;
    mem_raddr = row_idx;
    mem_wdata = '0;
    case (cmd.op)
      DP_CLEAR_WR: mem_we = 1'b1;
      DP_RD_ROW:   mem_re = 1'b1;
      DP_RD_NEXT: begin
        mem_re    = 1'b1;
        mem_raddr = row_idx + 1'b1;
      end
      DP_PT_WR: begin
        mem_we    = 1'b1;
        mem_wdata = rd_data | paint_mask;
      end
      DP_SW_EVAL: begin
        mem_we    = 1'b1;
        mem_wdata = row_cur_wr;
      end
      DP_SW_COLWR: begin
        mem_we    = 1'b1;
        mem_waddr = Y_W'(GRID_HEIGHT - 1);
        mem_wdata = row_buf;
      end
      default: mem_we = 1'b0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) mem[mem_waddr] <= mem_wdata;
    if (mem_re) rd_data <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      row_idx   <= '0;
      col_idx   <= '0;
      lfsr      <= LFSR_RESET;
      half_w    <= HALF_W_RESET;
      half_h    <= HALF_H_RESET;
      out_valid <= 1'b0;
    end else begin
      if (cfg_valid) begin
        case (cfg_reg_index)
          REG_LFSR_SEED:    lfsr <= (cfg_wr_data == '0) ? LFSR_RESET : cfg_wr_data;
          REG_BRUSH_HALF_W: half_w <= cfg_wr_data[5:0];
          REG_BRUSH_HALF_H: half_h <= cfg_wr_data[6:0];
          default: ;
        endcase
      end
      if (cmd.op == DP_RESP) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      case (cmd.op)
        DP_CLEAR_WR: row_idx <= row_idx + 1'b1;
        DP_LOAD: begin
          col_idx <= '0;
          case (in_operation)
            OP_PAINT: row_idx <= Y_W'(y_lo_in_c);
            OP_READ:  row_idx <= Y_W'(in_pos_y);
            default:  row_idx <= '0;
          endcase
        end
        DP_PT_WR: row_idx <= row_idx + 1'b1;
        DP_SW_EVAL: begin
          row_idx <= row_idx + 1'b1;
          if (draw) lfsr <= {lfsr_fb, lfsr[15:1]};
        end
        DP_SW_COLWR: begin
          row_idx <= '0;
          col_idx <= col_idx + 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_comb begin
    read_in_range = (int'(px_r) < GRID_WIDTH) && (int'(py_r) < GRID_HEIGHT);
  end

  always_ff @(posedge clk) begin
    case (cmd.op)
      DP_LOAD: begin
        op_r  <= in_operation;
        px_r  <= in_pos_x;
        py_r  <= in_pos_y;
        moves <= '0;
      end
      DP_CAP_ROW: row_buf <= rd_data;
      DP_SW_EVAL: begin
        row_buf <= row_buf_next;
        if (move && moves != MOVES_MAX) moves <= moves + 1'b1;
      end
      DP_RESP: begin
        out_cell_is_sand <= (op_r == OP_READ) && read_in_range && rd_data[X_W'(px_r)];
        out_grains_moved <= (op_r == OP_SWEEP) ? moves : '0;
      end
      default: ;
    endcase
  end

  function automatic logic y_lo_in_c_r_gt();
    logic signed [11:0] lo_c;
    lo_c = (y_lo < 12'sd0) ? 12'sd0 : y_lo;
    return lo_c > y_hi_c;
  endfunction

  always_comb begin
    status.clear_last  = (row_idx == Y_W'(GRID_HEIGHT - 1));
    status.pt_empty    = (half_w == '0) || (half_h == '0) ||
                         (y_lo_in_c_r_gt());
    status.pt_row_last = (row_idx == Y_W'(y_hi_c));
    status.sw_row_last = (row_idx == Y_W'(GRID_HEIGHT - 2));
    status.sw_col_last = (col_idx == X_W'(GRID_WIDTH - 1));
    status.out_busy    = out_valid && !out_ready;
  end

endmodule

>>> design/falling_sand_grid_engine_core.sv
// Channel | Dir | Payload                               | Handshake
// in_ch   | in  | operation[1:0] pos_x[7:0] pos_y[7:0]  | valid/ready
// out_ch  | out | cell_is_sand grains_moved[15:0]       | valid/ready
// cfg     | in  | reg_index[1:0] wr_data[15:0]          | valid/ready, ready always high
//
// Read: accept in idle, read the row, then issue the result. Paint: each painted row
// is read, then written; an empty brush goes straight to the result. Sweep: per cell,
// one read and one write of the row memory (one read port, one write port).
// After reset a clearing pass writes one row per cycle over all GRID_HEIGHT rows
// while no item is taken; configuration writes are taken throughout.
// One item at a time; a waiting result holds the next item only at its end.
module falling_sand_grid_engine_core
  import fsge_pkg::*;
(
  input logic          clk,
  input logic          rst,
  fsge_in_if.sink      in_ch,
  fsge_out_if.source   out_ch,
  fsge_cfg_if.sink     cfg
);

  cmd_t    cmd;
  status_t status;
  logic    in_ready;

  assign in_ch.ready = in_ready;
  assign cfg.ready   = 1'b1;

  fsge_ctrl u_ctrl (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_ch.valid),
    .in_operation (in_ch.operation),
    .status       (status),
    .in_ready     (in_ready),
    .cmd          (cmd)
  );

  fsge_dp u_dp (
    .clk              (clk),
    .rst              (rst),
    .cmd              (cmd),
    .status           (status),
    .in_operation     (in_ch.operation),
    .in_pos_x         (in_ch.pos_x),
    .in_pos_y         (in_ch.pos_y),
    .cfg_valid        (cfg.valid),
    .cfg_reg_index    (cfg.reg_index),
    .cfg_wr_data      (cfg.wr_data),
    .out_valid        (out_ch.valid),
    .out_ready        (out_ch.ready),
    .out_cell_is_sand (out_ch.cell_is_sand),
    .out_grains_moved (out_ch.grains_moved)
  );

`ifndef SYNTHESIS
  a_clear_blocks_input: assert property (@(posedge clk) disable iff (rst)
    $past(rst) |-> !in_ch.ready)
    else $error("item taken during clearing pass");

  a_one_item_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (in_ch.valid && in_ch.ready) |=> !in_ch.ready)
    else $error("second item taken while one is in work");

  a_result_fields_exclusive: assert property (@(posedge clk) disable iff (rst)
    (out_ch.valid && out_ch.cell_is_sand) |-> (out_ch.grains_moved == '0))
    else $error("read result carries a move count");
`endif

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import fsge_pkg::*;

  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 2'd3;
  localparam int PHASE_ITEMS = 20;
  localparam int NUM_PHASES = 5;
  localparam int CYCLE_LIMIT = 4_000_000;
  localparam int DIR_N = 20;

  typedef struct packed {
    logic        sand;
    logic [15:0] moved;
  } cell_result_t;

  typedef struct packed {
    logic [1:0]  op;
    logic [7:0]  x;
    logic [7:0]  y;
    logic        typed;
    logic        sand;
    logic [15:0] moved;
  } dir_row_t;

  localparam dir_row_t DIR_TABLE [DIR_N] = '{
    '{OP_READ,   8'd0,   8'd0,   1'b1, 1'b0, 16'd0},
    '{OP_READ,   8'd255, 8'd255, 1'b1, 1'b0, 16'd0},
    '{OP_SWEEP,  8'd0,   8'd0,   1'b1, 1'b0, 16'd0},
    '{OP_UNUSED, 8'd255, 8'd255, 1'b1, 1'b0, 16'd0},
    '{OP_PAINT,  8'd0,   8'd0,   1'b1, 1'b0, 16'd0},
    '{OP_READ,   8'd0,   8'd0,   1'b0, 1'b0, 16'd0},
    '{OP_READ,   8'd9,   8'd19,  1'b0, 1'b0, 16'd0},
    '{OP_READ,   8'd10,  8'd0,   1'b0, 1'b0, 16'd0},
    '{OP_PAINT,  8'd255, 8'd255, 1'b1, 1'b0, 16'd0},
    '{OP_READ,   8'd255, 8'd255, 1'b0, 1'b0, 16'd0},
    '{OP_READ,   8'd246, 8'd236, 1'b0, 1'b0, 16'd0},
    '{OP_PAINT,  8'd128, 8'd60,  1'b1, 1'b0, 16'd0},
    '{OP_READ,   8'd128, 8'd60,  1'b0, 1'b0, 16'd0},
    '{OP_SWEEP,  8'd7,   8'd200, 1'b0, 1'b0, 16'd0},
    '{OP_READ,   8'd128, 8'd255, 1'b0, 1'b0, 16'd0},
    '{OP_READ,   8'd0,   8'd255, 1'b0, 1'b0, 16'd0},
    '{OP_READ,   8'd128, 8'd60,  1'b0, 1'b0, 16'd0},
    '{OP_SWEEP,  8'd255, 8'd0,   1'b0, 1'b0, 16'd0},
    '{OP_UNUSED, 8'd0,   8'd0,   1'b1, 1'b0, 16'd0},
    '{OP_READ,   8'd127, 8'd254, 1'b0, 1'b0, 16'd0}
  };

  logic clk;
  logic rst;

  fsge_in_if  in_bus ();
  fsge_out_if res_bus ();
  fsge_cfg_if cfg_bus ();

  falling_sand_grid_engine_core u_top (
    .clk    (clk),
    .rst    (rst),
    .in_ch  (in_bus),
    .out_ch (res_bus),
    .cfg    (cfg_bus)
  );

  bit          sand_map [GRID_WIDTH][GRID_HEIGHT];
  logic [15:0] rng_state = LFSR_RESET;
  logic [5:0]  brush_w = HALF_W_RESET;
  logic [6:0]  brush_h = HALF_H_RESET;

  cell_result_t pending_results [$];
  int error_count = 0;
  int cycle_count = 0;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic cell_result_t apply_grid_item(logic [1:0] op, logic [7:0] px,
                                                   logic [7:0] py);
    cell_result_t res;
    int hw, hh, tx, moves;
    bit go, rbit, fb;
    res = '0;
    hw = brush_w;
    hh = brush_h;
    moves = 0;
    case (op)
      OP_PAINT: begin
        if (hw != 0 && hh != 0) begin
          for (int x = int'(px) - (hw - 1); x <= int'(px) + (hw - 1); x++)
            for (int y = int'(py) - (hh - 1); y <= int'(py) + (hh - 1); y++)
              if (x >= 0 && x < GRID_WIDTH && y >= 0 && y < GRID_HEIGHT)
                sand_map[x][y] = 1'b1;
        end
      end
      OP_SWEEP: begin
        for (int x = 0; x < GRID_WIDTH; x++)
          for (int y = 0; y + 1 < GRID_HEIGHT; y++)
            if (sand_map[x][y]) begin
              go = 1'b1;
              tx = x;
              if (sand_map[x][y+1]) begin
                if (x > 0 && x + 1 < GRID_WIDTH && y > 0) begin
                  rbit = rng_state[0];
                  fb = rng_state[0] ^ rng_state[2] ^ rng_state[3] ^ rng_state[5];
                  rng_state = {fb, rng_state[15:1]};
                  if (rbit && !sand_map[x-1][y+1]) tx = x - 1;
                  else if (!sand_map[x+1][y+1]) tx = x + 1;
                  else go = 1'b0;
                end else begin
                  go = 1'b0;
                end
              end
              if (go) begin
                sand_map[x][y] = 1'b0;
                sand_map[tx][y+1] = 1'b1;
                if (moves < 65535) moves++;
              end
            end
        res.moved = moves[15:0];
      end
      OP_READ: res.sand = sand_map[px][py];
      default: ;
    endcase
    return res;
  endfunction

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [15:0] data);
    @(negedge clk);
    cfg_bus.valid = 1'b1;
    cfg_bus.reg_index = idx;
    cfg_bus.wr_data = data;
    @(posedge clk);
    while (!cfg_bus.ready) @(posedge clk);
    case (idx)
      REG_LFSR_SEED:    rng_state = (data == 16'd0) ? 16'd1 : data;
      REG_BRUSH_HALF_W: brush_w = data[5:0];
      REG_BRUSH_HALF_H: brush_h = data[6:0];
      default: ;
    endcase
    @(negedge clk);
    cfg_bus.valid = 1'b0;
  endtask

  task automatic send_item(input logic [1:0] op, input logic [7:0] px, input logic [7:0] py,
                           input bit typed, input cell_result_t typed_res);
    cell_result_t res;
    while ($urandom_range(99) < tx_idle_pct) begin
      @(negedge clk);
      in_bus.valid = 1'b0;
    end
    @(negedge clk);
    in_bus.valid = 1'b1;
    in_bus.operation = op;
    in_bus.pos_x = px;
    in_bus.pos_y = py;
    @(posedge clk);
    while (!in_bus.ready) @(posedge clk);
    res = apply_grid_item(op, px, py);
    pending_results.push_back(typed ? typed_res : res);
  endtask

  task automatic drain_results();
    @(negedge clk);
    in_bus.valid = 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  always @(negedge clk) begin
    if (!rst) res_bus.ready = ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk) begin
    cell_result_t want;
    if (!rst && res_bus.valid && res_bus.ready) begin
      if (pending_results.size() == 0) begin
        error_count++;
        if (error_count <= 10)
          $display("unexpected item: sand=%0b moved=%0d", res_bus.cell_is_sand,
                   res_bus.grains_moved);
      end else begin
        want = pending_results.pop_front();
        if (res_bus.cell_is_sand !== want.sand || res_bus.grains_moved !== want.moved) begin
          error_count++;
          if (error_count <= 10)
            $display("mismatch: expected sand=%0b moved=%0d, got sand=%0b moved=%0d",
                     want.sand, want.moved, res_bus.cell_is_sand, res_bus.grains_moved);
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  initial begin
    int sweep_at, r, dx, last_cx, last_cy;
    logic [1:0] op;
    logic [7:0] px, py;
    rst = 1'b1;
    in_bus.valid = 1'b0;
    in_bus.operation = OP_PAINT;
    in_bus.pos_x = 8'd0;
    in_bus.pos_y = 8'd0;
    res_bus.ready = 1'b0;
    cfg_bus.valid = 1'b0;
    cfg_bus.reg_index = REG_LFSR_SEED;
    cfg_bus.wr_data = 16'd0;
    last_cx = 128;
    last_cy = 60;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    for (int i = 0; i < DIR_N; i++)
      send_item(DIR_TABLE[i].op, DIR_TABLE[i].x, DIR_TABLE[i].y, DIR_TABLE[i].typed,
                '{DIR_TABLE[i].sand, DIR_TABLE[i].moved});

    for (int ph = 0; ph < NUM_PHASES; ph++) begin
      drain_results();
      case (ph)
        0: begin
          write_reg(REG_LFSR_SEED, 16'hFFFF);
          write_reg(REG_BRUSH_HALF_W, 16'd1);
          write_reg(REG_BRUSH_HALF_H, 16'd1);
          tx_idle_pct = 74;
          rx_stall_pct = 0;
        end
        1: begin
          write_reg(REG_LFSR_SEED, 16'd0);
          write_reg(REG_BRUSH_HALF_W, 16'd63);
          write_reg(REG_BRUSH_HALF_H, 16'd127);
          write_reg(REG_UNUSED, 16'hFFFF);
          tx_idle_pct = 0;
          rx_stall_pct = 74;
        end
        2: begin
          write_reg(REG_LFSR_SEED, 16'($urandom_range(65535, 1)));
          write_reg(REG_BRUSH_HALF_W, 16'd32);
          write_reg(REG_BRUSH_HALF_H, 16'd64);
          tx_idle_pct = 18;
          rx_stall_pct = 18;
        end
        3: begin
          write_reg(REG_LFSR_SEED, 16'($urandom_range(65535, 1)));
          write_reg(REG_BRUSH_HALF_W, 16'd0);
          write_reg(REG_BRUSH_HALF_H, 16'($urandom_range(64, 1)));
          tx_idle_pct = 0;
          rx_stall_pct = 0;
        end
        default: begin
          write_reg(REG_LFSR_SEED, 16'($urandom));
          write_reg(REG_BRUSH_HALF_W, 16'($urandom_range(32, 1)));
          write_reg(REG_BRUSH_HALF_H, 16'($urandom_range(64, 0)));
          tx_idle_pct = 0;
          rx_stall_pct = 0;
        end
      endcase

      sweep_at = (ph == 3) ? -1 : int'($urandom_range(PHASE_ITEMS - 1, 4));
      for (int k = 0; k < PHASE_ITEMS; k++) begin
        r = $urandom_range(99);
        px = 8'($urandom);
        py = 8'($urandom);
        if (k == sweep_at) begin
          op = OP_SWEEP;
        end else if (r < 5) begin
          op = OP_UNUSED;
        end else if (r < 35) begin
          op = OP_PAINT;
          last_cx = px;
          last_cy = py;
        end else begin
          op = OP_READ;
          if (r < 70) begin
            dx = int'($urandom_range(2 * brush_w)) - int'(brush_w);
            px = 8'(last_cx + dx);
            dx = int'($urandom_range(2 * brush_h)) - int'(brush_h);
            py = 8'(last_cy + dx);
          end else if (r < 85) begin
            py = 8'($urandom_range(255, 230));
          end
        end
        send_item(op, px, py, 1'b0, '0);
      end
    end

    drain_results();
    if (error_count == 0 && pending_results.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
